### design/lapy_pkg.sv
// Shared constants, types and the arctangent table for the look-at pitch/yaw pipeline.
package lapy_pkg;

  // Coordinate and angle formats.
  localparam int COORD_BITS      = 32;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int CORDIC_STAGES   = 16;

  // Both vectors are normalised so that the larger member lies in [2^29, 2^30).
  localparam int NORM_BITS = 30;

  // Offset width, and the width of a bit length of an offset magnitude (plus one).
  localparam int D_W   = COORD_BITS + 1;
  localparam int LEN_W = $clog2(D_W + 2);

  // Sum of squares and the working width of the square-root cells.
  localparam int SUM_W      = 2 * NORM_BITS + 1;
  localparam int SQ_W       = 2 * NORM_BITS + 2;
  localparam int SQRT_STEPS = NORM_BITS + 1;
  localparam int SQ_IDX_W   = $clog2(SQRT_STEPS);

  // CORDIC datapath: x and y carry the gain of about 1.65 with headroom,
  // the angle is Q32 radians and must hold 3*pi/2.
  localparam int XY_W     = NORM_BITS + 4;
  localparam int ANG_W    = 36;
  localparam int CS_IDX_W = $clog2(CORDIC_STAGES);

  // Rounding of the Q32 angle down to the output resolution.
  localparam int RND_SH = 32 - ANGLE_FRAC_BITS;

  // Result fields.
  localparam int PITCH_W = 16;
  localparam int YAW_W   = 18;

  // Stream widths, padded to whole bytes.
  localparam int IN_FIELDS   = 6;
  localparam int IN_TDATA_W  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PITCH_W + YAW_W + 7) / 8) * 8;

  localparam logic signed [ANG_W-1:0] Q32_PI      = ANG_W'(64'sd13493037705);
  localparam logic signed [ANG_W-1:0] Q32_HALF_PI = ANG_W'(64'sd6746518852);

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  // atan(2^-i) in Q32 radians; from step 11 on it equals 2^(32-i) after rounding.
  function automatic logic signed [ANG_W-1:0] atan_q32(input logic [CS_IDX_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    case (32'(i))
      0:       a = ANG_W'(64'sd3373259426);
      1:       a = ANG_W'(64'sd1991351318);
      2:       a = ANG_W'(64'sd1052175346);
      3:       a = ANG_W'(64'sd534100635);
      4:       a = ANG_W'(64'sd268086748);
      5:       a = ANG_W'(64'sd134174063);
      6:       a = ANG_W'(64'sd67103403);
      7:       a = ANG_W'(64'sd33553749);
      8:       a = ANG_W'(64'sd16777131);
      9:       a = ANG_W'(64'sd8388597);
      10:      a = ANG_W'(64'sd4194303);
      default: a = ANG_W'(64'd1 << (32 - 32'(i)));
    endcase
    return a;
  endfunction

endpackage

### design/lapy_sqrt_cell.sv
// One digit step of the pipelined integer square root (two radicand bits per cell).
module lapy_sqrt_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [lapy_pkg::SQ_IDX_W-1:0]   idx,
  input  lapy_pkg::sqrt_t                 d_in,
  output lapy_pkg::sqrt_t                 d_out
);

  logic [lapy_pkg::SQ_W-1:0] probe;
  logic [lapy_pkg::SQ_W-1:0] trial;

  always_comb begin
    probe = lapy_pkg::SQ_W'(1) << (2 * (lapy_pkg::SQRT_STEPS - 1 - 32'(idx)));
    trial = d_in.res + probe;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_in.rem >= trial) begin
        d_out.rem <= d_in.rem - trial;
        d_out.res <= (d_in.res >> 1) + probe;
      end else begin
        d_out.rem <= d_in.rem;
        d_out.res <= d_in.res >> 1;
      end
    end
  end

endmodule

### design/lapy_cordic_cell.sv
// One CORDIC vectoring micro-rotation, registered, with its own arctangent constant.
module lapy_cordic_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [lapy_pkg::CS_IDX_W-1:0]   idx,
  input  lapy_pkg::cordic_t               d_in,
  output lapy_pkg::cordic_t               d_out
);

  logic signed [lapy_pkg::XY_W-1:0]  xs;
  logic signed [lapy_pkg::XY_W-1:0]  ys;
  logic signed [lapy_pkg::ANG_W-1:0] a;

  always_comb begin
    xs = d_in.x >>> idx;
    ys = d_in.y >>> idx;
    a  = lapy_pkg::atan_q32(idx);
  end

  // Rotate towards the x axis: the sign of y picks the direction.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!d_in.y[lapy_pkg::XY_W-1]) begin
        d_out.x <= d_in.x + ys;
        d_out.y <= d_in.y - xs;
        d_out.z <= d_in.z + a;
      end else begin
        d_out.x <= d_in.x - ys;
        d_out.y <= d_in.y + xs;
        d_out.z <= d_in.z - a;
      end
    end
  end

endmodule

### design/look_at_pitch_yaw_top.sv
// Top level of the look-at pitch/yaw pipeline: offsets, normalisation, square root, CORDIC.
// Path of a beat: the front stages, the 31 square-root cells, the normalisation register,
// the 16 CORDIC cells, the back-end stages and the output register.
// Throughput: one item per cycle while the skid stage is empty; every stage is a register.
// Reset (rst, synchronous) clears the stage valid bits and the output and skid valid bits;
// the payload registers are not reset and there is no clearing pass.
module look_at_pitch_yaw_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // from_x, from_y, from_z, to_x, to_y, to_z, each COORD_BITS signed, from the lowest bit up
  input  logic [lapy_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // pitch_angle (16 bits signed), yaw_angle (18 bits signed), zero padding, lowest bit up
  output logic [lapy_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  // Sign and zero flags of the offsets, worked out once and carried to the end.
  typedef struct packed {
    logic dz_nz;
    logic dz_pos;
    logic yaw_neg;
    logic dy_neg;
    logic xz_nz;
  } flag_t;

  // Everything the pitch normalisation needs once the square root is done.
  typedef struct packed {
    logic [lapy_pkg::NORM_BITS-1:0] nx;
    logic [lapy_pkg::NORM_BITS-1:0] nz;
    logic [lapy_pkg::D_W-1:0]       ay;
    logic [lapy_pkg::LEN_W-1:0]     lxz;
    logic [lapy_pkg::LEN_W-1:0]     lb;
    flag_t                          fl;
  } side_t;

  typedef struct packed {
    logic [lapy_pkg::YAW_W-1:0]   yaw;
    logic [lapy_pkg::PITCH_W-1:0] pitch;
  } result_t;

  localparam logic [lapy_pkg::ANG_W-1:0] RND_HALF =
    lapy_pkg::ANG_W'(1) << (lapy_pkg::RND_SH - 1);

  function automatic logic [lapy_pkg::LEN_W-1:0] bit_len(input logic [lapy_pkg::D_W-1:0] v);
    logic [lapy_pkg::LEN_W-1:0] n;
    n = '0;
    for (int k = 0; k < lapy_pkg::D_W; k++) begin
      if (v[k]) begin
        n = lapy_pkg::LEN_W'(k + 1);
      end
    end
    return n;
  endfunction

  function automatic logic signed [lapy_pkg::ANG_W-1:0] clamp_hp(
    input logic signed [lapy_pkg::ANG_W-1:0] z
  );
    logic signed [lapy_pkg::ANG_W-1:0] r;
    r = z;
    if (z > lapy_pkg::Q32_HALF_PI) begin
      r = lapy_pkg::Q32_HALF_PI;
    end
    if (z < -lapy_pkg::Q32_HALF_PI) begin
      r = -lapy_pkg::Q32_HALF_PI;
    end
    return r;
  endfunction

  // The whole chain moves together; it stops only while the skid stage is occupied,
  // so one beat can still enter while a finished result waits at the output.
  logic en;
  logic out_valid;
  logic skid_valid;
  logic out_take;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign out_take = !out_valid || m_tready;

  // Stage 0: offsets, observer minus target.
  logic signed [lapy_pkg::COORD_BITS-1:0] fx, fy, fz, tx, ty, tz;
  logic signed [lapy_pkg::D_W-1:0]        dx0, dy0, dz0;
  logic                                   v0;

  assign fx = s_tdata[0 * lapy_pkg::COORD_BITS +: lapy_pkg::COORD_BITS];
  assign fy = s_tdata[1 * lapy_pkg::COORD_BITS +: lapy_pkg::COORD_BITS];
  assign fz = s_tdata[2 * lapy_pkg::COORD_BITS +: lapy_pkg::COORD_BITS];
  assign tx = s_tdata[3 * lapy_pkg::COORD_BITS +: lapy_pkg::COORD_BITS];
  assign ty = s_tdata[4 * lapy_pkg::COORD_BITS +: lapy_pkg::COORD_BITS];
  assign tz = s_tdata[5 * lapy_pkg::COORD_BITS +: lapy_pkg::COORD_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      dx0 <= lapy_pkg::D_W'(fx) - lapy_pkg::D_W'(tx);
      dy0 <= lapy_pkg::D_W'(fy) - lapy_pkg::D_W'(ty);
      dz0 <= lapy_pkg::D_W'(fz) - lapy_pkg::D_W'(tz);
    end
  end

  // Stage 1: magnitudes and the sign and zero flags.
  logic [lapy_pkg::D_W-1:0] ax1, ay1, az1;
  flag_t                    fl1;
  logic                     v1;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1         <= dx0[lapy_pkg::D_W-1] ? $unsigned(-dx0) : $unsigned(dx0);
      ay1         <= dy0[lapy_pkg::D_W-1] ? $unsigned(-dy0) : $unsigned(dy0);
      az1         <= dz0[lapy_pkg::D_W-1] ? $unsigned(-dz0) : $unsigned(dz0);
      fl1.dz_nz   <= (dz0 != '0);
      fl1.dz_pos  <= !dz0[lapy_pkg::D_W-1] && (dz0 != '0);
      fl1.yaw_neg <= dx0[lapy_pkg::D_W-1] ^ dz0[lapy_pkg::D_W-1];
      fl1.dy_neg  <= dy0[lapy_pkg::D_W-1];
      fl1.xz_nz   <= (dx0 != '0) || (dz0 != '0);
    end
  end

  // Stage 2: leading-one search on the x/z pair and on the y magnitude.
  logic [lapy_pkg::D_W-1:0]   ax2, ay2, az2;
  logic [lapy_pkg::LEN_W-1:0] lxz2, lb2;
  flag_t                      fl2;
  logic                       v2;

  always_ff @(posedge clk) begin
    if (en) begin
      ax2  <= ax1;
      ay2  <= ay1;
      az2  <= az1;
      lxz2 <= bit_len(ax1 | az1);
      lb2  <= bit_len(ay1);
      fl2  <= fl1;
    end
  end

  // Stage 3: scale dx and dz by a common power of two; bits shifted out are dropped.
  side_t                        side3;
  logic                         v3;
  logic [lapy_pkg::NORM_BITS-1:0] nx2, nz2;

  always_comb begin
    if (32'(lxz2) > lapy_pkg::NORM_BITS) begin
      nx2 = lapy_pkg::NORM_BITS'(ax2 >> (32'(lxz2) - lapy_pkg::NORM_BITS));
      nz2 = lapy_pkg::NORM_BITS'(az2 >> (32'(lxz2) - lapy_pkg::NORM_BITS));
    end else begin
      nx2 = lapy_pkg::NORM_BITS'(ax2 << (lapy_pkg::NORM_BITS - 32'(lxz2)));
      nz2 = lapy_pkg::NORM_BITS'(az2 << (lapy_pkg::NORM_BITS - 32'(lxz2)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3.nx  <= nx2;
      side3.nz  <= nz2;
      side3.ay  <= ay2;
      side3.lxz <= lxz2;
      side3.lb  <= lb2;
      side3.fl  <= fl2;
    end
  end

  // Stages 4 and 5: squares, then their sum.
  logic [2*lapy_pkg::NORM_BITS-1:0] sqx4, sqz4;
  side_t                            side4, side5;
  logic [lapy_pkg::SUM_W-1:0]       sum5;
  logic                             v4, v5;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx4  <= (2*lapy_pkg::NORM_BITS)'(side3.nx) * (2*lapy_pkg::NORM_BITS)'(side3.nx);
      sqz4  <= (2*lapy_pkg::NORM_BITS)'(side3.nz) * (2*lapy_pkg::NORM_BITS)'(side3.nz);
      side4 <= side3;
      sum5  <= lapy_pkg::SUM_W'(sqx4) + lapy_pkg::SUM_W'(sqz4);
      side5 <= side4;
    end
  end

  // Square-root chain: one cell per result bit, side data delayed alongside.
  lapy_pkg::sqrt_t              sq_pipe [0:lapy_pkg::SQRT_STEPS];
  side_t                        side_d  [1:lapy_pkg::SQRT_STEPS];
  logic [lapy_pkg::SQRT_STEPS:1] vs;

  assign sq_pipe[0].rem = lapy_pkg::SQ_W'(sum5);
  assign sq_pipe[0].res = '0;

  for (genvar k = 0; k < lapy_pkg::SQRT_STEPS; k++) begin : g_sqrt
    lapy_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (lapy_pkg::SQ_IDX_W'(k)),
      .d_in  (sq_pipe[k]),
      .d_out (sq_pipe[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[1] <= side5;
      for (int k = 1; k < lapy_pkg::SQRT_STEPS; k++) begin
        side_d[k+1] <= side_d[k];
      end
    end
  end

  // Pitch normalisation: the horizontal distance is known only at the normalised scale,
  // so it is brought to a common exponent with |dy| before the pitch rotation starts.
  // The yaw vector is formed here as well so that both rotations run in step.
  side_t                          sq_side;
  logic [lapy_pkg::NORM_BITS:0]   dn;
  logic [lapy_pkg::LEN_W-1:0]     la, lmax, rsa;
  logic [lapy_pkg::NORM_BITS-1:0] pa, pb;

  assign sq_side = side_d[lapy_pkg::SQRT_STEPS];
  assign dn      = sq_pipe[lapy_pkg::SQRT_STEPS].res[lapy_pkg::NORM_BITS:0];

  always_comb begin
    la   = sq_side.lxz + lapy_pkg::LEN_W'(dn[lapy_pkg::NORM_BITS]);
    lmax = (la > sq_side.lb) ? la : sq_side.lb;
    rsa  = lmax - sq_side.lxz;
    pa   = lapy_pkg::NORM_BITS'(dn >> rsa);
    if (32'(lmax) > lapy_pkg::NORM_BITS) begin
      pb = lapy_pkg::NORM_BITS'(sq_side.ay >> (32'(lmax) - lapy_pkg::NORM_BITS));
    end else begin
      pb = lapy_pkg::NORM_BITS'(sq_side.ay << (lapy_pkg::NORM_BITS - 32'(lmax)));
    end
  end

  lapy_pkg::cordic_t                cp [0:lapy_pkg::CORDIC_STAGES];
  lapy_pkg::cordic_t                cy [0:lapy_pkg::CORDIC_STAGES];
  flag_t                            fl_c [0:lapy_pkg::CORDIC_STAGES];
  logic [lapy_pkg::CORDIC_STAGES:0] vc;

  always_ff @(posedge clk) begin
    if (en) begin
      cp[0].x <= lapy_pkg::XY_W'(pa);
      cp[0].y <= sq_side.fl.dy_neg ? -lapy_pkg::XY_W'(pb) : lapy_pkg::XY_W'(pb);
      cp[0].z <= '0;
      cy[0].x <= lapy_pkg::XY_W'(sq_side.nz);
      cy[0].y <= sq_side.fl.yaw_neg ? -lapy_pkg::XY_W'(sq_side.nx)
                                    : lapy_pkg::XY_W'(sq_side.nx);
      cy[0].z <= '0;
      fl_c[0] <= sq_side.fl;
    end
  end

  // Two parallel rows of CORDIC cells, pitch and yaw.
  for (genvar k = 0; k < lapy_pkg::CORDIC_STAGES; k++) begin : g_cordic
    lapy_cordic_cell u_pitch (
      .clk   (clk),
      .en    (en),
      .idx   (lapy_pkg::CS_IDX_W'(k)),
      .d_in  (cp[k]),
      .d_out (cp[k+1])
    );
    lapy_cordic_cell u_yaw (
      .clk   (clk),
      .en    (en),
      .idx   (lapy_pkg::CS_IDX_W'(k)),
      .d_in  (cy[k]),
      .d_out (cy[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < lapy_pkg::CORDIC_STAGES; k++) begin
        fl_c[k+1] <= fl_c[k];
      end
    end
  end

  // Back end, first stage: clamp any overshoot to +/-pi/2, add pi to yaw when dz is
  // positive, and force the degenerate cases (dz zero, or dx and dz both zero) to zero.
  flag_t                             fl_end;
  logic signed [lapy_pkg::ANG_W-1:0] zp6, zy6;
  logic                              vf1;

  assign fl_end = fl_c[lapy_pkg::CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      zp6 <= fl_end.xz_nz ? clamp_hp(cp[lapy_pkg::CORDIC_STAGES].z) : '0;
      zy6 <= fl_end.dz_nz ?
             clamp_hp(cy[lapy_pkg::CORDIC_STAGES].z) + (fl_end.dz_pos ? lapy_pkg::Q32_PI : '0)
             : '0;
    end
  end

  // Back end, second stage: sign and magnitude for rounding half away from zero.
  logic                       sp7, sy7;
  logic [lapy_pkg::ANG_W-1:0] mp7, my7;
  logic                       vf2;

  always_ff @(posedge clk) begin
    if (en) begin
      sp7 <= zp6[lapy_pkg::ANG_W-1];
      sy7 <= zy6[lapy_pkg::ANG_W-1];
      mp7 <= zp6[lapy_pkg::ANG_W-1] ? $unsigned(-zp6) : $unsigned(zp6);
      my7 <= zy6[lapy_pkg::ANG_W-1] ? $unsigned(-zy6) : $unsigned(zy6);
    end
  end

  // Rounding to the output resolution; the fields wrap to their widths.
  logic [lapy_pkg::ANG_W-1:0] rp, ry;
  result_t                    res_now;

  always_comb begin
    rp            = (mp7 + RND_HALF) >> lapy_pkg::RND_SH;
    ry            = (my7 + RND_HALF) >> lapy_pkg::RND_SH;
    res_now.pitch = lapy_pkg::PITCH_W'(sp7 ? -rp : rp);
    res_now.yaw   = lapy_pkg::YAW_W'(sy7 ? -ry : ry);
  end

  // Valid bits for every stage move with the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      vs  <= '0;
      vc  <= '0;
      vf1 <= 1'b0;
      vf2 <= 1'b0;
    end else if (en) begin
      v0  <= s_tvalid;
      v1  <= v0;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      vs  <= {vs[lapy_pkg::SQRT_STEPS-1:1], v5};
      vc  <= {vc[lapy_pkg::CORDIC_STAGES-1:0], vs[lapy_pkg::SQRT_STEPS]};
      vf1 <= vc[lapy_pkg::CORDIC_STAGES];
      vf2 <= vf1;
    end
  end

  // Output register with a one-entry skid stage behind it. When the consumer stalls,
  // the result leaving the chain lands in the skid stage and the chain then holds.
  result_t out_res, skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= vf2;
      end
    end else if (en && vf2) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_res <= skid_valid ? skid_res : res_now;
    end
    if (!out_take && en) begin
      skid_res <= res_now;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = lapy_pkg::OUT_TDATA_W'(out_res);

endmodule
